FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SCMC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define SCMC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define SCMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/scmc_pkg.sv
// Types and constants of the solar charge mode controller.
package scmc_pkg;

    localparam int VALUE_WIDTH  = 14;
    localparam int CUR_WIDTH    = 12;
    localparam int DUTY_WIDTH   = 14;
    localparam int TARGET_WIDTH = 9;
    localparam int CFG_IDX_W    = 3;

    localparam logic [DUTY_WIDTH-1:0]   DUTY_FULL   = DUTY_WIDTH'(10000);
    localparam logic [DUTY_WIDTH-1:0]   LED_FLOOR   = DUTY_WIDTH'(6000);
    localparam logic [DUTY_WIDTH-1:0]   STEP_BIG    = DUTY_WIDTH'(30);
    localparam logic [DUTY_WIDTH-1:0]   STEP_SMALL  = DUTY_WIDTH'(3);
    localparam logic [DUTY_WIDTH-1:0]   STEP_TAPER  = DUTY_WIDTH'(10);
    localparam logic [VALUE_WIDTH-1:0]  TAPER_MV    = VALUE_WIDTH'(8220);
    localparam logic [TARGET_WIDTH-1:0] TARGET_MAX  = TARGET_WIDTH'(325);
    localparam logic [TARGET_WIDTH-1:0] TARGET_HIGH = TARGET_WIDTH'(300);
    localparam logic [TARGET_WIDTH-1:0] TARGET_STEP = TARGET_WIDTH'(25);
    localparam logic [TARGET_WIDTH-1:0] TARGET_RST  = TARGET_WIDTH'(300);
    localparam logic [TARGET_WIDTH-1:0] BAND_MA     = TARGET_WIDTH'(15);
    localparam logic [7:0]              RX_DISABLE  = 8'h30;

    localparam logic [VALUE_WIDTH-1:0] SOLAR_MIN_RST = VALUE_WIDTH'(5000);
    localparam logic [VALUE_WIDTH-1:0] BATT_FULL_RST = VALUE_WIDTH'(8200);
    localparam logic [VALUE_WIDTH-1:0] BATT_RECH_RST = VALUE_WIDTH'(7800);
    localparam logic [VALUE_WIDTH-1:0] BATT_DIS_RST  = VALUE_WIDTH'(6400);
    localparam logic [VALUE_WIDTH-1:0] BATT_CUT_RST  = VALUE_WIDTH'(6000);
    localparam logic [CUR_WIDTH-1:0]   TAPER_MA_RST  = CUR_WIDTH'(200);

    typedef enum logic [1:0] {
        REQ_MEAS   = 2'd0,
        REQ_KEY    = 2'd1,
        REQ_ENABLE = 2'd2,
        REQ_TICK   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KEY_RAISE = 2'd0,
        KEY_LOWER = 2'd1,
        KEY_NEXT  = 2'd2
    } key_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOLAR_MIN = 3'd0,
        CFG_BATT_FULL = 3'd1,
        CFG_BATT_RECH = 3'd2,
        CFG_BATT_DIS  = 3'd3,
        CFG_BATT_CUT  = 3'd4,
        CFG_TAPER_MA  = 3'd5
    } cfg_idx_t;

    // Output codes of the mode field.
    localparam logic [1:0] MODE_CODE_STOP = 2'd0;
    localparam logic [1:0] MODE_CODE_VCHG = 2'd1;
    localparam logic [1:0] MODE_CODE_ICHG = 2'd2;
    localparam logic [1:0] MODE_CODE_LED  = 2'd3;

    typedef enum logic [3:0] {
        M_STOP = 4'b0001,
        M_VCHG = 4'b0010,
        M_ICHG = 4'b0100,
        M_LED  = 4'b1000
    } mode_t;

endpackage

FILE: rtl/core/solar_charge_mode_controller_core.sv
// Path from input transaction to result: input register, then state/result register.
// Throughput: one transaction per cycle without out_stall; each event is a single pass of compare/add logic.
// One input slot and the result register decouple the two channels under stall.
// Reset (rst_n low, asynchronous): mode stop, duties 0, LED target 300 mA, system enabled,
// thresholds at their defaults, no transaction held.
module solar_charge_mode_controller_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           req_type,
    input  logic [scmc_pkg::VALUE_WIDTH-1:0]     battery_mv,
    input  logic [scmc_pkg::VALUE_WIDTH-1:0]     solar_mv,
    input  logic [scmc_pkg::CUR_WIDTH-1:0]       led_ma,
    input  logic [scmc_pkg::CUR_WIDTH-1:0]       charge_ma,
    input  logic [1:0]                           key_code,
    input  logic [7:0]                           rx_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           mode,
    output logic [scmc_pkg::DUTY_WIDTH-1:0]      led_duty,
    output logic [scmc_pkg::DUTY_WIDTH-1:0]      charge_duty,
    output logic [scmc_pkg::TARGET_WIDTH-1:0]    led_target_ma,
    output logic                                 sys_enabled,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [scmc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scmc_pkg::VALUE_WIDTH-1:0]     cfg_data
);
    import scmc_pkg::*;

    // Threshold registers
    logic [VALUE_WIDTH-1:0] solar_min_reg, batt_full_reg, batt_rech_reg;
    logic [VALUE_WIDTH-1:0] batt_dis_reg, batt_cut_reg;
    logic [CUR_WIDTH-1:0]   taper_ma_reg;

    // Input slot
    logic                   s1_valid_reg;
    req_t                   req_reg;
    logic [VALUE_WIDTH-1:0] bat_reg, sol_reg;
    logic [CUR_WIDTH-1:0]   led_reg, chg_reg;
    logic [1:0]             key_reg;
    logic [7:0]             rx_reg;

    // Controller state, which is also the result register
    logic                    out_valid_reg;
    mode_t                   mode_reg, mode_next;
    logic [DUTY_WIDTH-1:0]   led_duty_reg, led_duty_next;
    logic [DUTY_WIDTH-1:0]   charge_duty_reg, charge_duty_next;
    logic [TARGET_WIDTH-1:0] target_reg, target_next;
    logic                    enable_reg, enable_next;

    logic in_accept, advance;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            solar_min_reg <= SOLAR_MIN_RST;
            batt_full_reg <= BATT_FULL_RST;
            batt_rech_reg <= BATT_RECH_RST;
            batt_dis_reg  <= BATT_DIS_RST;
            batt_cut_reg  <= BATT_CUT_RST;
            taper_ma_reg  <= TAPER_MA_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SOLAR_MIN: solar_min_reg <= cfg_data;
                CFG_BATT_FULL: batt_full_reg <= cfg_data;
                CFG_BATT_RECH: batt_rech_reg <= cfg_data;
                CFG_BATT_DIS:  batt_dis_reg  <= cfg_data;
                CFG_BATT_CUT:  batt_cut_reg  <= cfg_data;
                CFG_TAPER_MA:  taper_ma_reg  <= cfg_data[CUR_WIDTH-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg <= req_t'(req_type);
            bat_reg <= battery_mv;
            sol_reg <= solar_mv;
            led_reg <= led_ma;
            chg_reg <= charge_ma;
            key_reg <= key_code;
            rx_reg  <= rx_byte;
        end
    end

    // Event logic
    always_comb
    begin
        logic [DUTY_WIDTH-1:0]  ld, cd;
        mode_t                  m;
        logic [CUR_WIDTH-1:0]   band_hi;
        logic [CUR_WIDTH:0]     led_plus;
        logic [DUTY_WIDTH-1:0]  sum_big, sum_small;

        mode_next        = mode_reg;
        led_duty_next    = led_duty_reg;
        charge_duty_next = charge_duty_reg;
        target_next      = target_reg;
        enable_next      = enable_reg;
        ld       = led_duty_reg;
        cd       = charge_duty_reg;
        m        = mode_reg;
        band_hi  = CUR_WIDTH'(target_reg) + CUR_WIDTH'(BAND_MA);
        led_plus = {1'b0, led_reg} + (CUR_WIDTH+1)'(BAND_MA);
        sum_big  = '0;
        sum_small = '0;

        unique case (req_reg)
            REQ_MEAS:
            begin
                // Per-mode duty defaults, then the LED floor
                unique case (mode_reg)
                    M_STOP: begin cd = '0;        ld = DUTY_FULL; end
                    M_VCHG: begin cd = DUTY_FULL; ld = DUTY_FULL; end
                    M_ICHG: ld = DUTY_FULL;
                    M_LED:  cd = '0;
                    default: ;
                endcase
                if (ld < LED_FLOOR)
                    ld = LED_FLOOR;

                if (sol_reg <= solar_min_reg)
                begin
                    if (m == M_VCHG || m == M_ICHG)
                        m = M_LED;
                    if (bat_reg >= batt_dis_reg)
                        m = M_LED;
                    else if (bat_reg <= batt_cut_reg)
                        m = M_STOP;
                end
                else
                begin
                    if (m == M_LED)
                        m = M_STOP;
                    if (chg_reg <= taper_ma_reg && bat_reg >= batt_full_reg && m == M_ICHG)
                        m = M_STOP;
                    else if (bat_reg >= batt_full_reg && m == M_VCHG)
                        m = M_ICHG;
                    else if (bat_reg <= batt_rech_reg && m == M_STOP)
                        m = M_VCHG;
                end

                if (!enable_reg)
                    m = M_STOP;

                // Step the LED duty toward the target band
                if (m == M_LED)
                begin
                    sum_big   = ld + STEP_BIG;
                    sum_small = ld + STEP_SMALL;
                    if (led_reg > band_hi)
                        ld = (sum_big > DUTY_FULL) ? DUTY_FULL : sum_big;
                    else if (led_reg > CUR_WIDTH'(target_reg))
                        ld = (sum_small > DUTY_FULL) ? DUTY_FULL : sum_small;
                    else if (led_plus > (CUR_WIDTH+1)'(target_reg))
                        ld = (ld < STEP_SMALL) ? '0 : ld - STEP_SMALL;
                    else
                        ld = (ld < STEP_BIG) ? '0 : ld - STEP_BIG;
                end

                mode_next        = m;
                led_duty_next    = ld;
                charge_duty_next = cd;
            end
            REQ_KEY:
            begin
                case (key_reg)
                    KEY_RAISE:
                        if (mode_reg == M_LED)
                            target_next = (target_reg > TARGET_HIGH) ? TARGET_MAX
                                                                     : target_reg + TARGET_STEP;
                    KEY_LOWER:
                        if (mode_reg == M_LED)
                            target_next = (target_reg < TARGET_STEP) ? '0
                                                                     : target_reg - TARGET_STEP;
                    KEY_NEXT:
                    begin
                        unique case (mode_reg)
                            M_STOP:  mode_next = M_VCHG;
                            M_VCHG:  mode_next = M_ICHG;
                            M_ICHG:  mode_next = M_LED;
                            M_LED:   mode_next = M_STOP;
                            default: mode_next = M_STOP;
                        endcase
                    end
                    default: ;
                endcase
            end
            REQ_ENABLE:
                enable_next = (rx_reg != RX_DISABLE);
            REQ_TICK:
            begin
                // In current charge, taper the charge duty while charge current and battery voltage stay high
                if (mode_reg == M_ICHG && chg_reg > taper_ma_reg && bat_reg > TAPER_MV)
                    charge_duty_next = (charge_duty_reg < STEP_TAPER) ? '0
                                                                     : charge_duty_reg - STEP_TAPER;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            mode_reg        <= M_STOP;
            led_duty_reg    <= '0;
            charge_duty_reg <= '0;
            target_reg      <= TARGET_RST;
            enable_reg      <= 1'b1;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                mode_reg        <= mode_next;
                led_duty_reg    <= led_duty_next;
                charge_duty_reg <= charge_duty_next;
                target_reg      <= target_next;
                enable_reg      <= enable_next;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        unique case (mode_reg)
            M_STOP:  mode = MODE_CODE_STOP;
            M_VCHG:  mode = MODE_CODE_VCHG;
            M_ICHG:  mode = MODE_CODE_ICHG;
            M_LED:   mode = MODE_CODE_LED;
            default: mode = MODE_CODE_STOP;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign led_duty      = led_duty_reg;
    assign charge_duty   = charge_duty_reg;
    assign led_target_ma = target_reg;
    assign sys_enabled   = enable_reg;

endmodule

FILE: rtl/core/scmc_checker.sv
// Port-level checker for the solar charge mode controller, bound to solar_charge_mode_controller_core.
`include "assert_macros.svh"

module scmc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [1:0]                        mode,
    input logic [scmc_pkg::DUTY_WIDTH-1:0]   led_duty,
    input logic [scmc_pkg::DUTY_WIDTH-1:0]   charge_duty,
    input logic [scmc_pkg::TARGET_WIDTH-1:0] led_target_ma
);
    import scmc_pkg::*;

    // A held result keeps its valid and its fields
    `SCMC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(mode) && $stable(led_duty) && $stable(charge_duty) && $stable(led_target_ma))

    // Duties saturate at full scale
    `SCMC_ASSERT_IMPLY(a_duty_range, clk, rst_n, out_valid, led_duty <= DUTY_FULL && charge_duty <= DUTY_FULL)

    // Target never passes its ceiling
    `SCMC_ASSERT_ALWAYS(a_target_range, clk, rst_n, led_target_ma <= TARGET_MAX)

    // A fresh result follows an accepted input transaction held in the input slot
    `SCMC_ASSERT_IMPLY(a_out_origin, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind solar_charge_mode_controller_core scmc_checker u_scmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .mode          (mode),
    .led_duty      (led_duty),
    .charge_duty   (charge_duty),
    .led_target_ma (led_target_ma)
);
